>>> hdl/amsd_pkg.sv
// Shared constants, types and codes of the accelerometer step detector.
// No dependencies; every other file imports this package.

package amsd_pkg;

    // Field widths
    localparam int unsigned AXIS_W     = 15;
    localparam int unsigned MAG_W      = 2 * AXIS_W;   // 3 * 16384^2 < 2^30
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned THR_W      = 30;
    localparam int unsigned INT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(490000);
    localparam logic [INT_W-1:0] INT_RESET = INT_W'(250);

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_THR = 1'b0,
        CFG_MIN_INT = 1'b1
    } amsd_cfg_idx_t;

    // Low-pass divisor and its reciprocal: floor(n / 100) = (n * RECIP_MUL) >> RECIP_SHIFT,
    // exact for every n below 2^31
    localparam int unsigned LPF_DIV     = 100;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(LPF_DIV) - 64'd1) / 64'(LPF_DIV));
    localparam int unsigned PROD_W = MAG_W + 1 + RECIP_W;
    localparam int unsigned QUO_W  = PROD_W - RECIP_SHIFT;

    // Queue between front and back (power of two)
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Classified request handed from front to back
    typedef struct packed {
        logic              clear;
        logic [MAG_W-1:0]  mag;
        logic [TIME_W-1:0] time_ms;
    } amsd_item_t;

endpackage

>>> hdl/amsd_if.sv
// Handshake channels of the step detector: sample requests, results, register writes.
// Depends on amsd_pkg for the field widths.

interface amsd_sample_if import amsd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [AXIS_W-1:0] accel_x_mg;
    logic signed [AXIS_W-1:0] accel_y_mg;
    logic signed [AXIS_W-1:0] accel_z_mg;
    logic [TIME_W-1:0]        time_ms;

    modport source (output valid, req_type, accel_x_mg, accel_y_mg, accel_z_mg, time_ms,
                    input ready);
    modport sink   (input valid, req_type, accel_x_mg, accel_y_mg, accel_z_mg, time_ms,
                    output ready);
endinterface

interface amsd_result_if import amsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             step_seen;
    logic [CNT_W-1:0] steps_total;

    modport source (output valid, step_seen, steps_total, input ready);
    modport sink   (input valid, step_seen, steps_total, output ready);
endinterface

interface amsd_cfg_if import amsd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/amsd_front.sv
// Front stage: accepts requests, squares the three axes and registers the magnitude.
// Depends on amsd_pkg.

module amsd_front import amsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic signed [AXIS_W-1:0] accel_x_mg,
    input  logic signed [AXIS_W-1:0] accel_y_mg,
    input  logic signed [AXIS_W-1:0] accel_z_mg,
    input  logic [TIME_W-1:0]        time_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output amsd_item_t               out_item
);

    logic       valid_reg;
    logic       valid_next;
    amsd_item_t item_reg;
    amsd_item_t item_next;
    logic [AXIS_W-1:0] abs_x;
    logic [AXIS_W-1:0] abs_y;
    logic [AXIS_W-1:0] abs_z;
    logic [MAG_W-1:0]  sq_x;
    logic [MAG_W-1:0]  sq_y;
    logic [MAG_W-1:0]  sq_z;
    logic              take;

    // Magnitude of each axis; full negative scale gives 2^(AXIS_W-1)
    function automatic logic [AXIS_W-1:0] axis_abs(input logic signed [AXIS_W-1:0] v);
        return v[AXIS_W-1] ? AXIS_W'(~v + 1'b1) : AXIS_W'(v);
    endfunction

    assign abs_x = axis_abs(accel_x_mg);
    assign abs_y = axis_abs(accel_y_mg);
    assign abs_z = axis_abs(accel_z_mg);

    // Squared magnitude, three parallel multipliers and one adder
    assign sq_x = MAG_W'(abs_x) * MAG_W'(abs_x);
    assign sq_y = MAG_W'(abs_y) * MAG_W'(abs_y);
    assign sq_z = MAG_W'(abs_z) * MAG_W'(abs_z);

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        item_next         = item_reg;
        item_next.clear   = (req_type == REQ_CLEAR);
        item_next.mag     = sq_x + sq_y + sq_z;
        item_next.time_ms = time_ms;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hdl/amsd_queue.sv
// Short queue between the front and back stages; takes a push while full if a pop
// happens in the same cycle. Depends on amsd_pkg.

module amsd_queue import amsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  amsd_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output amsd_item_t out_item
);

    amsd_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg;
    logic [FIFO_CW-1:0]  count_next;
    logic                push;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg != FIFO_CW'(FIFO_DEPTH)) || pop;
    assign push      = in_valid && in_ready;
    assign out_item  = mem[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hdl/amsd_back.sv
// Back stage: baseline filter, step decision, step counter, result register and the
// configuration registers. Depends on amsd_pkg.

module amsd_back import amsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  amsd_item_t            in_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  step_seen,
    output logic [CNT_W-1:0]      steps_total
);

    logic [THR_W-1:0]  thr_reg;
    logic [INT_W-1:0]  int_reg;
    logic [MAG_W-1:0]  base_reg;
    logic [MAG_W-1:0]  base_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  total_next;
    logic              seen_next;
    logic              out_valid_reg;
    logic              out_seen_reg;
    logic [CNT_W-1:0]  out_total_reg;

    logic              take;
    logic              below;
    logic [MAG_W-1:0]  dev;
    logic [MAG_W:0]    num;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    logic [MAG_W-1:0]  base_filt;
    logic [TIME_W-1:0] elapsed;
    logic              step_hit;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Deviation from the baseline
    assign below = (in_item.mag < base_reg);
    assign dev   = below ? (base_reg - in_item.mag) : (in_item.mag - base_reg);

    // New baseline = base + floor((mag - base) / 100); the negative side rounds
    // toward minus infinity, hence the added divisor minus one
    assign num  = below ? ({1'b0, dev} + (MAG_W + 1)'(LPF_DIV - 1)) : {1'b0, dev};
    assign prod = PROD_W'(num) * PROD_W'(RECIP_MUL);
    assign quo  = prod[PROD_W-1:RECIP_SHIFT];
    assign base_filt = below ? (base_reg - MAG_W'(quo)) : (base_reg + MAG_W'(quo));

    // Step test, time difference wraps
    assign elapsed  = in_item.time_ms - last_reg;
    assign step_hit = (dev > MAG_W'(thr_reg))
                   && (elapsed > TIME_W'(int_reg));

    // State update for one request
    always_comb
    begin
        base_next  = base_reg;
        last_next  = last_reg;
        total_next = total_reg;
        seen_next  = 1'b0;
        if (in_item.clear)
        begin
            base_next  = '0;
            last_next  = '0;
            total_next = '0;
        end
        else if (base_reg == '0)
        begin
            base_next = in_item.mag;
        end
        else
        begin
            base_next = base_filt;
            if (step_hit)
            begin
                total_next = total_reg + 1'b1;
                last_next  = in_item.time_ms;
                seen_next  = 1'b1;
            end
        end
    end

    // Detector state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            last_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                base_reg      <= base_next;
                last_reg      <= last_next;
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_seen_reg  <= seen_next;
            out_total_reg <= total_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            int_reg <= INT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (amsd_cfg_idx_t'(cfg_index))
                CFG_DEV_THR: thr_reg <= cfg_data[THR_W-1:0];
                CFG_MIN_INT: int_reg <= cfg_data[INT_W-1:0];
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign step_seen   = out_seen_reg;
    assign steps_total = out_total_reg;

endmodule

>>> hdl/accel_magnitude_step_detector_top.sv
// Top level of the accelerometer step detector: front stage, queue, back stage.
// Depends on amsd_pkg, amsd_if, amsd_front, amsd_queue and amsd_back.
//
//   channel  role    carries
//   -------  ------  -----------------------------------------------------------
//   sample   sink    req_type, accel_x_mg, accel_y_mg, accel_z_mg, time_ms
//   result   source  step_seen, steps_total (one result per request)
//   cfg      sink    index, data (0: deviation_threshold, 1: min_step_interval_ms)
//
// One request per cycle sustained while results are taken; each request is registered in
// turn in the front register, a queue entry and the back register. The rate is set by the
// baseline recurrence in the back stage: one reciprocal multiply and add per cycle.
// Reset clears the baseline, last step time and count; no clearing pass is needed.
// A stalled result holds the back stage; the queue and the front register absorb three
// more requests before sample.ready drops. cfg is always ready.

module accel_magnitude_step_detector_top import amsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    amsd_sample_if.sink   sample,
    amsd_result_if.source result,
    amsd_cfg_if.sink      cfg
);

    logic       fr_valid;
    logic       fr_ready;
    amsd_item_t fr_item;
    logic       bk_valid;
    logic       bk_ready;
    amsd_item_t bk_item;

    // Request intake and magnitude
    amsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .req_type   (sample.req_type),
        .accel_x_mg (sample.accel_x_mg),
        .accel_y_mg (sample.accel_y_mg),
        .accel_z_mg (sample.accel_z_mg),
        .time_ms    (sample.time_ms),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_item   (fr_item)
    );

    // Decoupling queue
    amsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_item  (bk_item)
    );

    // Baseline, step decision and result
    amsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (bk_valid),
        .in_ready    (bk_ready),
        .in_item     (bk_item),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .step_seen   (result.step_seen),
        .steps_total (result.steps_total)
    );

endmodule

>>> hdl/amsd_checker.sv
// Port-level checks of the step detector and the bind that attaches them.
// Depends on amsd_pkg and accel_magnitude_step_detector_top.

module amsd_checker import amsd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input logic             step_seen,
    input logic [CNT_W-1:0] steps_total,
    input logic             cfg_ready
);

    // No result can come out of reset or the cycle after it
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid right after reset");

    // While results drain, the pipeline never pushes back on requests
    a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("sample stalled while result side is ready");

    // Register writes are never stalled
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg channel not ready");

    // A stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready
        |=> result_valid && $stable(step_seen) && $stable(steps_total))
        else $error("stalled result changed");

endmodule

bind accel_magnitude_step_detector_top amsd_checker u_amsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .step_seen    (result.step_seen),
    .steps_total  (result.steps_total),
    .cfg_ready    (cfg.ready)
);
